/* hdl/iacomp_pkg.sv */
// Shared types and constants for the indexed-alpha layer compositor.
package iacomp_pkg;

  localparam logic [2:0] MODE_NORMAL     = 3'd0;
  localparam logic [2:0] MODE_BEHIND     = 3'd1;
  localparam logic [2:0] MODE_REPLACE    = 3'd2;
  localparam logic [2:0] MODE_ERASE      = 3'd3;
  localparam logic [2:0] MODE_ANTI_ERASE = 3'd4;

  localparam logic [2:0] CFG_BLEND_MODE    = 3'd0;
  localparam logic [2:0] CFG_OPACITY       = 3'd1;
  localparam logic [2:0] CFG_AFFECT_INDEX  = 3'd2;
  localparam logic [2:0] CFG_ALPHA_WRITE   = 3'd3;
  localparam logic [2:0] CFG_MASK_ENABLE   = 3'd4;
  localparam logic [2:0] CFG_TOP_HAS_ALPHA = 3'd5;

  localparam logic [7:0]  MUL2_BIAS    = 8'h80;
  localparam logic [15:0] MUL3_BIAS    = 16'h7F5B;
  localparam logic [7:0]  ALPHA_THRESH = 8'd127;
  localparam logic [7:0]  ALPHA_FULL   = 8'hFF;

  typedef struct packed {
    logic [2:0] blend_mode;
    logic [7:0] opacity;
    logic       affect_index;
    logic       alpha_write;
    logic       mask_enable;
    logic       top_has_alpha;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bottom_index;
    logic [7:0] bottom_alpha;
    logic [7:0] top_index;
    logic [7:0] top_alpha;
    logic [7:0] eff_alpha;
    logic       last;
  } pix_t;

  typedef struct packed {
    logic        valid;
    pix_t        pix;
    logic [24:0] t3;
    logic [16:0] t2;
  } prod_t;

endpackage

/* hdl/iacomp_scale.sv */
// Alpha scaling stages: mask, opacity and top alpha products with rounding bias.
module iacomp_scale import iacomp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  pix_t       in_pix,
  input  logic [7:0] mask_value,
  output prod_t      prod
);

  logic        v1;
  pix_t        pix1;
  logic [15:0] am;
  logic [15:0] mo;
  logic [7:0]  m_eff;
  logic [7:0]  mul2_lhs;

  assign m_eff    = cfg.mask_enable ? mask_value : ALPHA_FULL;
  assign mul2_lhs = (cfg.blend_mode == MODE_REPLACE) ? m_eff : in_pix.eff_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1 <= in_pix;
      am   <= in_pix.eff_alpha * m_eff;
      mo   <= mul2_lhs * cfg.opacity;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.pix <= pix1;
      prod.t3  <= 25'(am) * 25'(cfg.opacity) + 25'(MUL3_BIAS);
      prod.t2  <= 17'(mo) + 17'(MUL2_BIAS);
    end
  end

endmodule

/* hdl/iacomp_blend.sv */
// Final stage: rounding shifts, threshold, mode select and output register.
module iacomp_blend import iacomp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  cfg_t       cfg,
  input  prod_t      st,
  output logic       out_valid,
  output logic [7:0] out_index,
  output logic [7:0] out_alpha,
  output logic       out_last
);

  logic [25:0] sum3;
  logic [17:0] sum2;
  logic [7:0]  s3;
  logic [7:0]  s2;
  logic        on3;
  logic        on_norm;
  logic        on_behind;
  logic        rep_hit;
  logic [7:0]  idx_next;
  logic [7:0]  alpha_next;

  assign sum3 = 26'(st.t3) + 26'(st.t3 >> 7);
  assign sum2 = 18'(st.t2) + 18'(st.t2 >> 8);
  assign s3   = sum3[23:16];
  assign s2   = sum2[15:8];

  assign on3       = s3 > ALPHA_THRESH;
  assign on_norm   = cfg.mask_enable ? on3 : (s2 > ALPHA_THRESH);
  assign on_behind = on3 && (st.pix.bottom_alpha > ALPHA_THRESH);
  assign rep_hit   = s2 != 8'd0;

  always_comb begin
    idx_next   = st.pix.bottom_index;
    alpha_next = st.pix.bottom_alpha;
    case (cfg.blend_mode)
      MODE_NORMAL: begin
        if (cfg.affect_index && on_norm) idx_next = st.pix.top_index;
        if (cfg.alpha_write && on_norm) alpha_next = ALPHA_FULL;
      end
      MODE_BEHIND: begin
        if (cfg.affect_index && on_behind) idx_next = st.pix.top_index;
        if (cfg.alpha_write && on_behind) alpha_next = st.pix.eff_alpha;
      end
      MODE_REPLACE: begin
        if (cfg.affect_index && rep_hit) idx_next = st.pix.top_index;
        if (cfg.top_has_alpha && cfg.alpha_write && rep_hit) alpha_next = st.pix.top_alpha;
      end
      MODE_ERASE: begin
        if (on3) alpha_next = 8'd0;
      end
      MODE_ANTI_ERASE: begin
        if (on3) alpha_next = ALPHA_FULL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= st.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_index <= idx_next;
      out_alpha <= alpha_next;
      out_last  <= st.pix.last;
    end
  end

  a_erase_alpha: assert property (@(posedge clk) disable iff (rst)
    en && st.valid && (cfg.blend_mode == MODE_ERASE)
    |=> (out_alpha == 8'd0) || (out_alpha == $past(st.pix.bottom_alpha)))
    else $error("erase produced an alpha other than zero or bottom");

  a_erase_index: assert property (@(posedge clk) disable iff (rst)
    en && st.valid && (cfg.blend_mode == MODE_ERASE || cfg.blend_mode == MODE_ANTI_ERASE)
    |=> out_index == $past(st.pix.bottom_index))
    else $error("erase modes changed the index");

  a_normal_alpha: assert property (@(posedge clk) disable iff (rst)
    en && st.valid && (cfg.blend_mode == MODE_NORMAL)
    |=> (out_alpha == ALPHA_FULL) || (out_alpha == $past(st.pix.bottom_alpha)))
    else $error("normal mode produced a partial alpha");

endmodule

/* hdl/indexed_alpha_layer_compositor_top.sv */
// Top level of the indexed-alpha layer compositor: config registers and pipeline.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata 40b pixel pair, s_tlast row end
//  m_*      out  m_tvalid/m_tready  m_tdata 16b result, m_tlast row end
//  cfg_*    in   cfg_we             cfg_index 3b, cfg_data 8b
//
//  One item per cycle unless m_tready stalls; three register stages, the last sets m_tvalid.
//  Stages: operand multiply, opacity multiply with bias, shift/threshold/select.
//  All stages advance together whenever the output register is empty or taken.
//  rst clears the valid bits and loads the register reset values.
module indexed_alpha_layer_compositor_top import iacomp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // bottom_index[7:0], bottom_alpha[15:8], top_index[23:16], top_alpha[31:24],
  // mask_value[39:32]
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_index[7:0], out_alpha[15:8]
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t       cfg;
  pix_t       in_pix;
  prod_t      prod;
  logic       en;
  logic [7:0] out_index;
  logic [7:0] out_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode    <= MODE_NORMAL;
      cfg.opacity       <= ALPHA_FULL;
      cfg.affect_index  <= 1'b1;
      cfg.alpha_write   <= 1'b1;
      cfg.mask_enable   <= 1'b0;
      cfg.top_has_alpha <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLEND_MODE:    cfg.blend_mode    <= cfg_data[2:0];
        CFG_OPACITY:       cfg.opacity       <= cfg_data;
        CFG_AFFECT_INDEX:  cfg.affect_index  <= cfg_data[0];
        CFG_ALPHA_WRITE:   cfg.alpha_write   <= cfg_data[0];
        CFG_MASK_ENABLE:   cfg.mask_enable   <= cfg_data[0];
        CFG_TOP_HAS_ALPHA: cfg.top_has_alpha <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign in_pix.bottom_index = s_tdata[7:0];
  assign in_pix.bottom_alpha = s_tdata[15:8];
  assign in_pix.top_index    = s_tdata[23:16];
  assign in_pix.top_alpha    = s_tdata[31:24];
  assign in_pix.eff_alpha    = cfg.top_has_alpha ? s_tdata[31:24] : ALPHA_FULL;
  assign in_pix.last         = s_tlast;

  iacomp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_pix     (in_pix),
    .mask_value (s_tdata[39:32]),
    .prod       (prod)
  );

  iacomp_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .st        (prod),
    .out_valid (m_tvalid),
    .out_index (out_index),
    .out_alpha (out_alpha),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_alpha, out_index};

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while output register free");

endmodule
